@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
// Each macro wraps one concurrent assertion reporting through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed: label");
`define ASSERT_CHK(label, prop) `ASSERT_IMPL(label, clk_i, rst_ni, prop)
`endif

@@ design/tsi_pkg.sv @@
// Package for the track state initializer: shared types and constants.
// Used by the front, queue, back and top-level modules.
`timescale 1ns / 1ps
package tsi_pkg;
  localparam int unsigned CfgPoints = 0;
  localparam int unsigned CfgGap    = 1;
  localparam int unsigned CfgSmall  = 2;

  // Item handed from the front to the back through the queue.
  typedef struct packed {
    logic        keep;
    logic        est;       // estimation due on this beat
    logic [31:0] t;
    logic [31:0] v;
    logic [31:0] t1;
    logic [31:0] v1;
    logic [31:0] t2;
    logic [31:0] v2;
  } job_t;

  // Outcome of a back-end estimation, fed back to the front.
  typedef struct packed {
    logic valid;
    logic ok;
  } done_t;

  typedef enum logic [3:0] {
    B_IDLE, B_CHK_DT, B_DIV_S, B_WAIT_S, B_CHK_S, B_DIV_S0, B_WAIT_S0,
    B_CHK_D, B_DIV_A, B_WAIT_A, B_CHK_A, B_OUT
  } back_state_e;
endpackage

@@ design/tsi_div.sv @@
// Signed iterative divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
module tsi_div #(
  parameter int W = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] num_i,
  input  logic        [W-1:0] den_i,  // positive
  output logic                busy_o,
  output logic signed [W-1:0] quo_o
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic         neg_q;
  logic [CW-1:0] cnt_q;
  logic [W:0]   trial;

  assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = {quo_q[W-2:0], 1'b0};
    if (!trial[W]) begin
      rem_d = trial[W-1:0];
      quo_d[0] = 1'b1;
    end else begin
      rem_d = {rem_q[W-2:0], quo_q[W-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[W-1] ? W'(-num_i) : W'(num_i);
      neg_q <= num_i[W-1];
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

@@ design/tsi_front.sv @@
// Front part: keep/reject decision, history, kept count and ready flag.
// Depends on tsi_pkg; sends jobs to the queue and takes back results.
`timescale 1ns / 1ps
module tsi_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [31:0]   t_i,
  input  logic [31:0]   v_i,
  input  logic [7:0]    points_i,
  input  logic [31:0]   gap_i,
  input  tsi_pkg::done_t done_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output tsi_pkg::job_t job_o,
  output logic          init_o
);
  logic [31:0] ht_q [3];
  logic [31:0] hv_q [3];
  logic [7:0]  cnt_q;
  logic        init_q, wait_q;
  logic [31:0] gap;
  logic        keep, acc;
  logic [7:0]  need, cnt_n;

  assign gap  = (t_i >= ht_q[0]) ? t_i - ht_q[0] : ht_q[0] - t_i;
  assign keep = !init_q && ((cnt_q == 8'd0) || (gap > gap_i));
  assign need = (points_i < 8'd2) ? 8'd2 : points_i;
  assign cnt_n = (cnt_q == 8'd255) ? cnt_q : cnt_q + 8'd1;
  // An estimate decides the ready flag, so intake waits for its outcome.
  assign in_ready_o  = job_ready_i && !wait_q;
  assign job_valid_o = in_valid_i && !wait_q;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    job_o.keep = keep;
    job_o.est  = keep && (cnt_n >= need);
    job_o.t  = t_i;     job_o.v  = v_i;
    job_o.t1 = ht_q[0]; job_o.v1 = hv_q[0];
    job_o.t2 = ht_q[1]; job_o.v2 = hv_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; init_q <= 1'b0; wait_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ht_q[i] <= '0; hv_q[i] <= '0;
      end
    end else begin
      if (acc && keep) begin
        ht_q[2] <= ht_q[1]; ht_q[1] <= ht_q[0]; ht_q[0] <= t_i;
        hv_q[2] <= hv_q[1]; hv_q[1] <= hv_q[0]; hv_q[0] <= v_i;
        cnt_q <= cnt_n;
        if (cnt_n >= need) wait_q <= 1'b1;
      end
      if (done_i.valid) begin
        wait_q <= 1'b0;
        if (done_i.ok) init_q <= 1'b1;
      end
    end
  end

  assign init_o = init_q;
endmodule

@@ design/tsi_queue.sv @@
// Two-entry queue of jobs between the front and the back.
// Depends on tsi_pkg for the job type.
`timescale 1ns / 1ps
module tsi_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  tsi_pkg::job_t wr_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output tsi_pkg::job_t rd_o
);
  tsi_pkg::job_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] n_q;
  logic       wr, rd;

  assign wr_ready_o = (n_q != 2'd2);
  assign rd_valid_o = (n_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; n_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      n_q <= n_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_i;
  end
endmodule

@@ design/tsi_back.sv @@
// Back part: estimation sequencer over a shared divider and result register.
// Depends on tsi_pkg and tsi_div.
`timescale 1ns / 1ps
module tsi_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  tsi_pkg::job_t       job_i,
  input  logic [7:0]          points_i,
  input  logic [15:0]         small_i,
  output tsi_pkg::done_t      done_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                ready_res_o,
  output logic                accepted_o,
  output logic [31:0]         out_time_o,
  output logic signed [31:0]  out_value_o,
  output logic [22:0]         out_step_o,
  output logic signed [30:0]  out_speed_o,
  output logic signed [23:0]  out_accel_o
);
  localparam logic signed [63:0] One = 64'sd1 <<< FRAC_BITS;
  tsi_pkg::back_state_e st_q, st_d;
  tsi_pkg::job_t j_q;
  logic signed [63:0] dt_q, s_q, s0_q, diff_q, a_q;
  logic        ok_q, hold_q, rdy_q, has_q;
  logic [31:0] ht_q, hv_q, hs_q, hsp_q, ha_q;
  logic        div_start, div_busy;
  logic signed [63:0] num, quo, dt_c, adt, den;
  logic        fin;

  assign dt_c = $signed({32'd0, j_q.t}) - $signed({32'd0, j_q.t1});

  tsi_div #(.W(64)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(den),
    .busy_o(div_busy), .quo_o(quo)
  );

  function automatic logic signed [63:0] abs64(input logic signed [63:0] x);
    abs64 = x[63] ? -x : x;
  endfunction

  always_comb begin
    st_d = st_q;
    case (st_q)
      tsi_pkg::B_IDLE:   if (job_valid_i && !has_q) st_d = tsi_pkg::B_CHK_DT;
      tsi_pkg::B_CHK_DT: begin
        if (!j_q.est || rdy_q) st_d = tsi_pkg::B_OUT;
        else if (dt_c <= 0 || dt_c < $signed({48'd0, small_i}) || dt_c > 100 * One)
          st_d = tsi_pkg::B_OUT;
        else st_d = tsi_pkg::B_DIV_S;
      end
      tsi_pkg::B_DIV_S:  st_d = tsi_pkg::B_WAIT_S;
      tsi_pkg::B_WAIT_S: if (!div_busy) st_d = tsi_pkg::B_CHK_S;
      tsi_pkg::B_CHK_S: begin
        if (abs64(s_q) < $signed({48'd0, small_i}) || abs64(s_q) > 10000 * One)
          st_d = tsi_pkg::B_OUT;
        else if (points_i > 8'd2) st_d = tsi_pkg::B_DIV_S0;
        else st_d = tsi_pkg::B_OUT;
      end
      tsi_pkg::B_DIV_S0:  st_d = tsi_pkg::B_WAIT_S0;
      tsi_pkg::B_WAIT_S0: if (!div_busy) st_d = tsi_pkg::B_CHK_D;
      tsi_pkg::B_CHK_D:
        st_d = (abs64(diff_q) > 101 * dt_q) ? tsi_pkg::B_OUT : tsi_pkg::B_DIV_A;
      tsi_pkg::B_DIV_A:  st_d = tsi_pkg::B_WAIT_A;
      tsi_pkg::B_WAIT_A: if (!div_busy) st_d = tsi_pkg::B_CHK_A;
      tsi_pkg::B_CHK_A:  st_d = tsi_pkg::B_OUT;
      tsi_pkg::B_OUT:    st_d = tsi_pkg::B_IDLE;
      default:           st_d = tsi_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    num = '0;
    den = dt_q;
    adt = $signed({32'd0, j_q.t1}) - $signed({32'd0, j_q.t2});
    fin = (st_q == tsi_pkg::B_OUT);
    case (st_q)
      tsi_pkg::B_DIV_S: begin
        div_start = 1'b1;
        num = ($signed({{32{j_q.v[31]}}, j_q.v}) - $signed({{32{j_q.v1[31]}}, j_q.v1}))
              <<< FRAC_BITS;
      end
      tsi_pkg::B_DIV_S0: begin
        // An older interval of zero yields a zero rate; otherwise signed divide.
        div_start = (adt != 0);
        num = ($signed({{32{j_q.v1[31]}}, j_q.v1}) - $signed({{32{j_q.v2[31]}}, j_q.v2}))
              <<< FRAC_BITS;
        den = adt[63] ? -adt : adt;
        if (adt[63]) num = -num;
      end
      tsi_pkg::B_DIV_A: begin
        div_start = 1'b1;
        num = diff_q <<< FRAC_BITS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tsi_pkg::B_IDLE; rdy_q <= 1'b0; has_q <= 1'b0;
      ht_q <= '0; hv_q <= '0; hs_q <= '0; hsp_q <= '0; ha_q <= '0;
    end else begin
      st_q <= st_d;
      if (has_q && out_ready_i) has_q <= 1'b0;
      if (fin) begin
        has_q <= 1'b1;
        if (hold_q) begin
          rdy_q <= 1'b1;
          ht_q <= j_q.t; hv_q <= j_q.v; hs_q <= dt_q[31:0];
          hsp_q <= s_q[31:0]; ha_q <= (points_i > 8'd2) ? a_q[31:0] : 32'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == tsi_pkg::B_IDLE && job_valid_i && !has_q) begin
      j_q <= job_i;
      hold_q <= 1'b0;
    end
    case (st_q)
      tsi_pkg::B_CHK_DT: dt_q <= dt_c;
      tsi_pkg::B_WAIT_S: s_q <= quo;
      tsi_pkg::B_CHK_S:
        if (!(abs64(s_q) < $signed({48'd0, small_i}) || abs64(s_q) > 10000 * One)
            && points_i <= 8'd2) hold_q <= 1'b1;
      tsi_pkg::B_WAIT_S0: if (!div_busy) begin
        s0_q <= (adt == 0) ? 64'sd0 : quo;
      end
      tsi_pkg::B_CHK_D: diff_q <= diff_q;
      tsi_pkg::B_WAIT_A: a_q <= quo;
      tsi_pkg::B_CHK_A: if (abs64(a_q) <= 100 * One) hold_q <= 1'b1;
      default: ;
    endcase
    if (st_q == tsi_pkg::B_WAIT_S0 && !div_busy)
      diff_q <= s_q - ((adt == 0) ? 64'sd0 : quo);
  end

  always_comb begin
    done_o.valid = fin && j_q.est && !rdy_q;
    done_o.ok    = hold_q;
  end

  // Result register: one beat per job, held until taken.
  logic        r_rdy_q, r_acc_q;
  logic [31:0] r_t_q, r_v_q, r_s_q, r_sp_q, r_a_q;
  always_ff @(posedge clk_i) begin
    if (fin) begin
      r_rdy_q <= rdy_q || hold_q;
      r_acc_q <= j_q.keep;
      if (rdy_q) begin
        r_t_q <= ht_q; r_v_q <= hv_q; r_s_q <= hs_q; r_sp_q <= hsp_q; r_a_q <= ha_q;
      end else if (hold_q) begin
        r_t_q <= j_q.t; r_v_q <= j_q.v; r_s_q <= dt_q[31:0]; r_sp_q <= s_q[31:0];
        r_a_q <= (points_i > 8'd2) ? a_q[31:0] : 32'd0;
      end else begin
        r_t_q <= j_q.t; r_v_q <= j_q.v; r_s_q <= '0; r_sp_q <= '0; r_a_q <= '0;
      end
    end
  end

  assign job_ready_o = (st_q == tsi_pkg::B_IDLE) && !has_q;
  assign out_valid_o = has_q;
  assign ready_res_o = r_rdy_q;
  assign accepted_o  = r_acc_q;
  assign out_time_o  = r_t_q;
  assign out_value_o = r_v_q;
  assign out_step_o  = r_s_q[22:0];
  assign out_speed_o = r_sp_q[30:0];
  assign out_accel_o = r_a_q[23:0];
  logic unused;
  assign unused = ^s0_q;
endmodule

@@ design/track_state_initializer_unit.sv @@
// Top level of the track state initializer.
// Depends on tsi_pkg, tsi_front, tsi_queue, tsi_back and tsi_div.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one sample beat: time, value.
//   Output channel (out_valid_o/out_ready_i) gives one result beat per sample.
//   Config channel (cfg_valid_i/cfg_ready_o) writes points_needed (0),
//   min_gap (1) and small_limit (2); it is always ready.
// A sample without estimation passes through the queue and the back states
// for idle, interval check and output into the result register. A sample
// that triggers estimation uses the 64-bit iterative divider for speed, older
// speed and acceleration in turn; intake pauses until that estimate is decided.
// Once ready, results repeat the latched estimate.
// Reset clears history, counts, the ready flag and restores the registers
// to 3, 655 and 1. When the receiver stalls the result is held in the
// output register and a short queue absorbs further samples.
module track_state_initializer_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        sample_time_i,
  input  logic signed [31:0] sample_value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ready_res_o,
  output logic               accepted_o,
  output logic [31:0]        out_time_o,
  output logic signed [31:0] out_value_o,
  output logic [22:0]        out_step_o,
  output logic signed [30:0] out_speed_o,
  output logic signed [23:0] out_accel_o
);
  logic [7:0]  points_q;
  logic [31:0] gap_q;
  logic [15:0] small_q;
  tsi_pkg::job_t  fj, bj;
  tsi_pkg::done_t done;
  logic fv, fr, bv, br, init;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= 8'd3; gap_q <= 32'd655; small_q <= 16'd1;
    end else if (cfg_valid_i) begin
      case (32'(cfg_index_i))
        tsi_pkg::CfgPoints: points_q <= cfg_data_i[7:0];
        tsi_pkg::CfgGap:    gap_q    <= cfg_data_i;
        tsi_pkg::CfgSmall:  small_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  tsi_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .t_i(sample_time_i),
    .v_i(sample_value_i), .points_i(points_q), .gap_i(gap_q), .done_i(done),
    .job_valid_o(fv), .job_ready_i(fr), .job_o(fj), .init_o(init)
  );

  tsi_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_i(fj),
    .rd_valid_o(bv), .rd_ready_i(br), .rd_o(bj)
  );

  tsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(bv), .job_ready_o(br), .job_i(bj),
    .points_i(points_q), .small_i(small_q), .done_o(done),
    .out_valid_o, .out_ready_i, .ready_res_o, .accepted_o, .out_time_o,
    .out_value_o, .out_step_o, .out_speed_o, .out_accel_o
  );

  logic unused;
  assign unused = init;
endmodule

@@ design/tsi_checker.sv @@
// Port-level checker for the track state initializer, with its bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tsi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        ready_res_o,
  input logic        accepted_o,
  input logic [22:0] out_step_o
);
  `ASSERT_CHK(a_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  `ASSERT_CHK(a_ready_sticky, out_valid_o && ready_res_o |=> !out_valid_o || ready_res_o)
  `ASSERT_CHK(a_zero_step, out_valid_o && !ready_res_o |-> out_step_o == 23'd0)
  `ASSERT_CHK(a_no_keep_late, out_valid_o && ready_res_o && $past(out_valid_o && ready_res_o)
    && !$past(accepted_o) |-> !accepted_o || $past(out_ready_i))
endmodule

bind track_state_initializer_unit tsi_checker u_tsi_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .ready_res_o, .accepted_o, .out_step_o
);
